// ===== design/ubxf_pkg.sv =====
// ----------------------------------------------------------------------------
// ubxf_pkg
// Types, constants and field tables shared by the frame field extractor.
// ----------------------------------------------------------------------------
package ubxf_pkg;

  // Header and id codes
  localparam logic [7:0] SYNC1  = 8'hB5;
  localparam logic [7:0] SYNC2  = 8'h62;
  localparam logic [7:0] ID_POS = 8'h02;
  localparam logic [7:0] ID_STA = 8'h03;
  localparam logic [7:0] ID_VEL = 8'h12;
  localparam logic [7:0] ID_PVT = 8'h07;

  // Capture lengths (length, payload and checksum bytes)
  localparam int unsigned IDX_W = 7;
  localparam logic [IDX_W-1:0] LEN_POS = 7'd32;
  localparam logic [IDX_W-1:0] LEN_STA = 7'd20;
  localparam logic [IDX_W-1:0] LEN_VEL = 7'd40;
  localparam logic [IDX_W-1:0] LEN_PVT = 7'd96;

  // Output sideband width: frame id and field code
  localparam int unsigned USER_W = 12;

  typedef enum logic [1:0] {
    HS_HUNT,
    HS_SYNC1,
    HS_SYNC2,
    HS_CLASS
  } hdr_state_t;

  // How a field is cut out of the two half-words read from the frame store
  typedef enum logic [1:0] {
    FK_WORD,
    FK_HALF,
    FK_LO,
    FK_HI
  } fld_kind_t;

  typedef struct packed {
    logic [3:0]       code;
    logic [IDX_W-1:0] off;
    fld_kind_t        kind;
  } fld_t;

  // Hand-over of a completed capture to the emitter
  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic       bank;
  } job_t;

  function automatic logic [IDX_W-1:0] capture_len(input logic [7:0] id);
    logic [IDX_W-1:0] len;
    unique case (id)
      ID_STA:  len = LEN_STA;
      ID_POS:  len = LEN_POS;
      ID_VEL:  len = LEN_VEL;
      ID_PVT:  len = LEN_PVT;
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] field_count(input logic [7:0] id);
    logic [3:0] n;
    unique case (id)
      ID_POS:  n = 4'd4;
      ID_STA:  n = 4'd2;
      ID_VEL:  n = 4'd6;
      ID_PVT:  n = 4'd13;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic fld_t mk_fld(input logic [3:0] code, input logic [IDX_W-1:0] off,
                                  input fld_kind_t kind);
    fld_t f;
    f.code = code;
    f.off  = off;
    f.kind = kind;
    return f;
  endfunction

  // Field k of a frame: code, byte offset into the capture, extraction kind
  function automatic fld_t field_entry(input logic [7:0] id, input logic [3:0] k);
    fld_t f;
    f = mk_fld(4'd0, 7'd0, FK_WORD);
    unique case (id)
      ID_POS: begin
        unique case (k)
          4'd0:    f = mk_fld(4'd0, 7'd10, FK_WORD);
          4'd1:    f = mk_fld(4'd1, 7'd6,  FK_WORD);
          4'd2:    f = mk_fld(4'd2, 7'd14, FK_WORD);
          4'd3:    f = mk_fld(4'd3, 7'd18, FK_WORD);
          default: f = mk_fld(4'd0, 7'd0,  FK_WORD);
        endcase
      end
      ID_STA: begin
        unique case (k)
          4'd0:    f = mk_fld(4'd4, 7'd2, FK_WORD);
          4'd1:    f = mk_fld(4'd5, 7'd6, FK_LO);
          default: f = mk_fld(4'd0, 7'd0, FK_WORD);
        endcase
      end
      ID_VEL: begin
        unique case (k)
          4'd0:    f = mk_fld(4'd6,  7'd6,  FK_WORD);
          4'd1:    f = mk_fld(4'd7,  7'd10, FK_WORD);
          4'd2:    f = mk_fld(4'd8,  7'd14, FK_WORD);
          4'd3:    f = mk_fld(4'd9,  7'd18, FK_WORD);
          4'd4:    f = mk_fld(4'd10, 7'd22, FK_WORD);
          4'd5:    f = mk_fld(4'd11, 7'd26, FK_WORD);
          default: f = mk_fld(4'd0,  7'd0,  FK_WORD);
        endcase
      end
      ID_PVT: begin
        unique case (k)
          4'd0:    f = mk_fld(4'd0,  7'd30, FK_WORD);
          4'd1:    f = mk_fld(4'd1,  7'd26, FK_WORD);
          4'd2:    f = mk_fld(4'd2,  7'd34, FK_WORD);
          4'd3:    f = mk_fld(4'd3,  7'd38, FK_WORD);
          4'd4:    f = mk_fld(4'd5,  7'd22, FK_LO);
          4'd5:    f = mk_fld(4'd6,  7'd50, FK_WORD);
          4'd6:    f = mk_fld(4'd7,  7'd54, FK_WORD);
          4'd7:    f = mk_fld(4'd8,  7'd58, FK_WORD);
          4'd8:    f = mk_fld(4'd11, 7'd66, FK_WORD);
          4'd9:    f = mk_fld(4'd12, 7'd24, FK_HI);
          4'd10:   f = mk_fld(4'd13, 7'd78, FK_HALF);
          4'd11:   f = mk_fld(4'd14, 7'd70, FK_WORD);
          4'd12:   f = mk_fld(4'd15, 7'd46, FK_WORD);
          default: f = mk_fld(4'd0,  7'd0,  FK_WORD);
        endcase
      end
      default: f = mk_fld(4'd0, 7'd0, FK_WORD);
    endcase
    return f;
  endfunction

endpackage

// ===== design/ubxf_frame_ram.sv =====
// ----------------------------------------------------------------------------
// ubxf_frame_ram
// Half-word frame store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ubxf_frame_ram #(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [15:0]   rd_data0,
  output logic [15:0]   rd_data1
);

  localparam int DEPTH = 1 << AW;

  logic [15:0] mem [DEPTH];

  // Write one half-word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two half-words, hold while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== design/ubxf_capture.sv =====
// ----------------------------------------------------------------------------
// ubxf_capture
// Header hunt and frame capture: pairs bytes into half-words for the store
// and hands each completed frame to the emitter.
// ----------------------------------------------------------------------------
module ubxf_capture #(
  parameter int CAPTURE_BYTES = 96,
  parameter int AW            = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic           job_ready,
  output ubxf_pkg::job_t job,
  output logic           wr_en,
  output logic [AW:0]    wr_addr,
  output logic [15:0]    wr_data
);

  import ubxf_pkg::*;

  localparam logic [7:0] CAP_LIM = 8'(CAPTURE_BYTES);

  hdr_state_t       hdr_state;
  hdr_state_t       hdr_state_next;
  logic             frame_active;
  logic [7:0]       cur_id;
  logic [IDX_W-1:0] cap_len;
  logic [IDX_W-1:0] cap_idx;
  logic [7:0]       lo_byte;
  logic             bank;

  logic             accept;
  logic             cap_last;
  logic             idx_ok;
  logic             frame_start;
  logic [IDX_W-1:0] new_len;

  assign accept      = s_tvalid && s_tready;
  assign cap_last    = (cap_idx == cap_len - 7'd1);
  assign idx_ok      = ({1'b0, cap_idx} < CAP_LIM);
  assign new_len     = capture_len(s_tdata);
  assign frame_start = accept && !frame_active && (hdr_state == HS_CLASS) && (new_len != '0);

  // Header state: next value
  always_comb begin
    hdr_state_next = hdr_state;
    if (accept && !frame_active) begin
      unique case (hdr_state)
        HS_HUNT:  hdr_state_next = (s_tdata == SYNC1) ? HS_SYNC1 : HS_HUNT;
        HS_SYNC1: hdr_state_next = (s_tdata == SYNC2) ? HS_SYNC2 : HS_HUNT;
        HS_SYNC2: hdr_state_next = HS_CLASS;
        HS_CLASS: hdr_state_next = HS_HUNT;
        default:  hdr_state_next = HS_HUNT;
      endcase
    end
  end

  // Outputs: stall the closing byte while the emitter still reads the other bank
  always_comb begin
    s_tready  = !(frame_active && cap_last && !job_ready);
    wr_en     = accept && frame_active && cap_idx[0] && idx_ok;
    wr_addr   = {bank, AW'(cap_idx[IDX_W-1:1])};
    wr_data   = {s_tdata, lo_byte};
    job.valid = accept && frame_active && cap_last;
    job.id    = cur_id;
    job.bank  = bank;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_state    <= HS_HUNT;
      frame_active <= 1'b0;
      cur_id       <= '0;
      cap_len      <= '0;
      cap_idx      <= '0;
      bank         <= 1'b0;
    end else begin
      hdr_state <= hdr_state_next;
      if (accept && frame_active) begin
        cap_idx <= cap_idx + 7'd1;
        if (cap_last) begin
          frame_active <= 1'b0;
          bank         <= ~bank;
        end
      end else if (frame_start) begin
        frame_active <= 1'b1;
        cur_id       <= s_tdata;
        cap_len      <= new_len;
        cap_idx      <= '0;
      end
    end
  end

  // Hold the even byte until its odd partner arrives
  always_ff @(posedge clk) begin
    if (accept && frame_active) begin
      lo_byte <= s_tdata;
    end
  end

endmodule

// ===== design/ubxf_emit.sv =====
// ----------------------------------------------------------------------------
// ubxf_emit
// Field sequencer: walks a frame's field table, reads the store and drives
// the output register.
// ----------------------------------------------------------------------------
module ubxf_emit #(
  parameter int AW = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ubxf_pkg::job_t              job,
  output logic                        job_ready,
  output logic                        rd_en,
  output logic [AW:0]                 rd_addr0,
  output logic [AW:0]                 rd_addr1,
  input  logic [15:0]                 rd_data0,
  input  logic [15:0]                 rd_data1,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,
  output logic [ubxf_pkg::USER_W-1:0] m_tuser,
  output logic                        m_tlast
);

  import ubxf_pkg::*;

  // Sequencer
  logic       active;
  logic [7:0] e_id;
  logic       e_bank;
  logic [3:0] k;

  // Read stage (store data arrives with it)
  logic       r_v;
  logic [7:0] r_id;
  logic [3:0] r_code;
  fld_kind_t  r_kind;
  logic       r_last;

  // Output stage
  logic        o_v;
  logic [7:0]  o_id;
  logic [3:0]  o_code;
  logic [31:0] o_value;
  logic        o_last;

  fld_t        fld;
  logic [3:0]  cnt;
  logic        k_last;
  logic        adv_o;
  logic        issue;
  logic [AW-1:0] hw_addr;
  logic [31:0] value;

  assign fld       = field_entry(e_id, k);
  assign cnt       = field_count(e_id);
  assign k_last    = (k == cnt - 4'd1);
  assign adv_o     = !o_v || m_tready;
  assign issue     = active && (!r_v || adv_o);
  assign job_ready = !active;
  assign hw_addr   = AW'(fld.off[IDX_W-1:1]);
  assign rd_en     = issue;
  assign rd_addr0  = {e_bank, hw_addr};
  assign rd_addr1  = {e_bank, hw_addr + AW'(1)};

  // Cut the field out of the two half-words
  always_comb begin
    unique case (r_kind)
      FK_WORD: value = {rd_data1, rd_data0};
      FK_HALF: value = {16'd0, rd_data0};
      FK_LO:   value = {24'd0, rd_data0[7:0]};
      FK_HI:   value = {24'd0, rd_data0[15:8]};
      default: value = '0;
    endcase
  end

  // Control: sequencer and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
      r_v    <= 1'b0;
      o_v    <= 1'b0;
    end else begin
      if (job.valid) begin
        active <= 1'b1;
        k      <= '0;
      end else if (issue) begin
        k <= k + 4'd1;
        if (k_last) begin
          active <= 1'b0;
        end
      end
      if (issue) begin
        r_v <= 1'b1;
      end else if (adv_o) begin
        r_v <= 1'b0;
      end
      if (adv_o) begin
        o_v <= r_v;
      end
    end
  end

  // Payload: frame identity, read metadata and output beat
  always_ff @(posedge clk) begin
    if (job.valid) begin
      e_id   <= job.id;
      e_bank <= job.bank;
    end
    if (issue) begin
      r_id   <= e_id;
      r_code <= fld.code;
      r_kind <= fld.kind;
      r_last <= k_last;
    end
    if (adv_o && r_v) begin
      o_id    <= r_id;
      o_code  <= r_code;
      o_value <= value;
      o_last  <= r_last;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = o_value;
  assign m_tuser  = {o_code, o_id};
  assign m_tlast  = o_last;

endmodule

// ===== design/ubx_nav_frame_field_extractor.sv =====
// ----------------------------------------------------------------------------
// ubx_nav_frame_field_extractor
// Hunts navigation frames in a byte stream and emits their fields as beats.
// ----------------------------------------------------------------------------
// One received byte is taken every cycle. After the sync pair, class and a
// known id (status, position, velocity, pvt) the capture bytes are written
// into a half-word frame store with two banks; once the closing byte is in,
// the frame's fields leave one beat per cycle while the output takes them,
// passing the sequencer, read and output registers, while the next frame is
// captured into the other bank. Each beat needs one access of the store's
// two read ports. The input stalls only on the closing byte of a frame whose
// predecessor is still being read out, which happens when the output side
// holds back. The store needs no clearing pass after reset.
module ubx_nav_frame_field_extractor #(
  parameter int CAPTURE_BYTES = 96
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [31:0] field_value
  output logic [ubxf_pkg::USER_W-1:0] m_tuser,   // [7:0] message_id, [11:8] field_code
  output logic                        m_tlast    // last_field
);

  import ubxf_pkg::*;

  localparam int HW_DEPTH = (CAPTURE_BYTES + 1) / 2;
  localparam int HW_AW    = $clog2(HW_DEPTH);

  job_t          job;
  logic          job_ready;
  logic          wr_en;
  logic [HW_AW:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [HW_AW:0] rd_addr0;
  logic [HW_AW:0] rd_addr1;
  logic [15:0]   rd_data0;
  logic [15:0]   rd_data1;

  // Header hunt and capture
  ubxf_capture #(
    .CAPTURE_BYTES (CAPTURE_BYTES),
    .AW            (HW_AW)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_ready (job_ready),
    .job       (job),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Double-banked frame store
  ubxf_frame_ram #(
    .AW (HW_AW + 1)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // Field read-out
  ubxf_emit #(
    .AW (HW_AW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_ready (job_ready),
    .rd_en     (rd_en),
    .rd_addr0  (rd_addr0),
    .rd_addr1  (rd_addr1),
    .rd_data0  (rd_data0),
    .rd_data1  (rd_data1),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== design/ubxf_checker.sv =====
// ----------------------------------------------------------------------------
// ubxf_checker
// Port-level checks of the field extractor's streams.
// ----------------------------------------------------------------------------
module ubxf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [7:0]                  s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [31:0]                 m_tdata,
  input logic [ubxf_pkg::USER_W-1:0] m_tuser,
  input logic                        m_tlast
);

  import ubxf_pkg::*;

  logic [7:0] beat_id;

  assign beat_id = m_tuser[7:0];

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input beat changed while stalled");

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Every beat belongs to a known frame id
  a_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (beat_id == ID_POS) || (beat_id == ID_STA) ||
                 (beat_id == ID_VEL) || (beat_id == ID_PVT))
    else $error("beat carries an unknown frame id");

  // A frame's fields follow without gaps and keep their id
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tuser[7:0] == $past(m_tuser[7:0])))
    else $error("frame field run broken");

endmodule

bind ubx_nav_frame_field_extractor ubxf_checker u_ubxf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== verif/ubx_nav_frame_field_extractor_test.sv =====
// ----------------------------------------------------------------------------
// ubx_nav_frame_field_extractor_test
// Self-checking bench for the navigation frame field extractor.
// ----------------------------------------------------------------------------
// Received bytes are pushed into the slave stream, and the extracted field
// beats are taken from the master stream. A scoreboard keeps its own copy of
// the header hunter and the capture store. It works out the field beats that
// each accepted byte completes and checks every output beat, field by field,
// in order. The bytes start with a short directed sequence: sync mismatch, no
// resync on a repeated first sync, an unknown id, and a status frame with
// sync bytes and extreme values in its body. Random traffic follows in four
// idling phases and is mostly well-formed frames, with some noise and broken
// headers mixed in.
module ubx_nav_frame_field_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ubxf_pkg::*;

  localparam int STORE_BYTES  = 96;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [3:0] {
    FC_LAT, FC_LON, FC_HEIGHT, FC_HMSL, FC_TOW, FC_FIX, FC_VEL_N, FC_VEL_E,
    FC_VEL_D, FC_SPEED3D, FC_GSPEED, FC_HEADING, FC_SATS, FC_PDOP, FC_SACC, FC_VACC
  } field_code_t;

  typedef struct packed {
    logic [7:0]  id;
    field_code_t code;
    logic [31:0] value;
    logic        last;
  } nav_beat_t;

  // Bytes captured after the id, zero for ids that open no frame
  function automatic int unsigned frame_span(input logic [7:0] id);
    case (id)
      ID_STA:  return 20;
      ID_POS:  return 32;
      ID_VEL:  return 40;
      ID_PVT:  return 96;
      default: return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: header hunter, capture store and queue of pending field beats
  // --------------------------------------------------------------------------
  class nav_field_scoreboard;
    nav_beat_t   pending[$];
    int          errors;
    hdr_state_t  hdr;
    bit          in_frame;
    logic [7:0]  cur_id;
    int unsigned left;
    logic [7:0]  store [STORE_BYTES];

    function new();
      hdr       = HS_HUNT;
      in_frame  = 1'b0;
      cur_id    = '0;
      left      = 0;
      errors    = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    // Queue one field read little-endian from the capture store
    function void add_field(field_code_t code, int unsigned off, int unsigned size);
      nav_beat_t b;
      b.id    = cur_id;
      b.code  = code;
      b.value = '0;
      b.last  = 1'b0;
      for (int i = 0; i < size; i++) b.value[8*i +: 8] = store[off + i];
      pending.push_back(b);
    endfunction

    function void queue_fields();
      case (cur_id)
        ID_POS: begin
          add_field(FC_LAT, 10, 4);
          add_field(FC_LON, 6, 4);
          add_field(FC_HEIGHT, 14, 4);
          add_field(FC_HMSL, 18, 4);
        end
        ID_STA: begin
          add_field(FC_TOW, 2, 4);
          add_field(FC_FIX, 6, 1);
        end
        ID_VEL: begin
          add_field(FC_VEL_N, 6, 4);
          add_field(FC_VEL_E, 10, 4);
          add_field(FC_VEL_D, 14, 4);
          add_field(FC_SPEED3D, 18, 4);
          add_field(FC_GSPEED, 22, 4);
          add_field(FC_HEADING, 26, 4);
        end
        ID_PVT: begin
          add_field(FC_LAT, 30, 4);
          add_field(FC_LON, 26, 4);
          add_field(FC_HEIGHT, 34, 4);
          add_field(FC_HMSL, 38, 4);
          add_field(FC_FIX, 22, 1);
          add_field(FC_VEL_N, 50, 4);
          add_field(FC_VEL_E, 54, 4);
          add_field(FC_VEL_D, 58, 4);
          add_field(FC_HEADING, 66, 4);
          add_field(FC_SATS, 25, 1);
          add_field(FC_PDOP, 78, 2);
          add_field(FC_SACC, 70, 4);
          add_field(FC_VACC, 46, 4);
        end
        default: return;
      endcase
      pending[$].last = 1'b1;
    endfunction

    // Advance the hunter or the capture by one accepted byte
    function void take_byte(logic [7:0] b);
      int unsigned span;
      int unsigned idx;
      if (in_frame) begin
        span = frame_span(cur_id);
        idx  = span - left;
        if (left <= span && idx < STORE_BYTES) store[idx] = b;
        if (left > 0) left--;
        if (left == 0) begin
          queue_fields();
          in_frame = 1'b0;
          hdr      = HS_HUNT;
        end
        return;
      end
      if (b == SYNC1 && hdr == HS_HUNT) hdr = HS_SYNC1;
      else if (b == SYNC2 && hdr == HS_SYNC1) hdr = HS_SYNC2;
      else if (hdr == HS_SYNC2) hdr = HS_CLASS;
      else if (hdr == HS_CLASS) begin
        hdr = HS_HUNT;
        if (frame_span(b) != 0) begin
          cur_id   = b;
          left     = frame_span(b);
          in_frame = 1'b1;
        end
      end else hdr = HS_HUNT;
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    // Compare one output beat with the oldest pending field
    function void check_beat(nav_beat_t got);
      nav_beat_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.id !== want.id)       report("message_id", want.id, got.id);
      if (got.code !== want.code)   report("field_code", want.code, got.code);
      if (got.value !== want.value) report("field_value", want.value, got.value);
      if (got.last !== want.last)   report("last_field", want.last, got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic [USER_W-1:0] m_tuser;
  logic              m_tlast;

  nav_field_scoreboard sb = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int bytes_sent     = 0;
  int cycles         = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ubx_nav_frame_field_extractor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Stall the output side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Take output beats; handshake signals are settled by the falling edge
  always @(negedge clk) begin : watch_out
    nav_beat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.id    = m_tuser[7:0];
      got.code  = field_code_t'(m_tuser[11:8]);
      got.value = m_tdata;
      got.last  = m_tlast;
      sb.check_beat(got);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge that accepts the byte
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // Frame body byte, weighted towards sync values and extremes
  function automatic logic [7:0] body_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return SYNC1;
    if (r < 15) return SYNC2;
    if (r < 25) return 8'h00;
    if (r < 35) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame(input logic [7:0] id);
    send_byte(SYNC1);
    send_byte(SYNC2);
    send_byte(8'($urandom_range(255)));
    send_byte(id);
    for (int i = 0; i < frame_span(id); i++) send_byte(body_byte());
  endtask

  task automatic send_random_segment();
    int unsigned r;
    logic [7:0]  id;
    r = $urandom_range(99);
    if (r < 70) begin
      // well-formed frame of a known id
      case ($urandom_range(3))
        0:       id = ID_STA;
        1:       id = ID_POS;
        2:       id = ID_VEL;
        default: id = ID_PVT;
      endcase
      send_frame(id);
    end else if (r < 80) begin
      // header with an id that opens no frame, then a few stray bytes
      do id = 8'($urandom_range(255)); while (frame_span(id) != 0);
      send_frame(id);
      repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
    end else if (r < 90) begin
      // first sync followed by anything, often a second first sync
      send_byte(SYNC1);
      send_byte(($urandom_range(1) != 0) ? SYNC1 : 8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_bytes);
    int bytes0;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    bytes0 = bytes_sent;
    while (bytes_sent - bytes0 < n_bytes)
      send_random_segment();
  endtask

  task automatic run_directed();
    logic [7:0] sta_body [20] = '{
      8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, SYNC1, SYNC2, 8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'h7F, SYNC1, SYNC2, 8'h01, 8'h02, 8'hAA, 8'h55
    };
    // mismatch after the first sync
    send_byte(SYNC1);
    send_byte(8'h00);
    // a repeated first sync must not restart the header
    send_byte(SYNC1);
    send_byte(SYNC1);
    send_byte(SYNC2);
    // id that opens no frame
    send_byte(SYNC1);
    send_byte(SYNC2);
    send_byte(8'h01);
    send_byte(8'hFF);
    // status frame: sync bytes inside the body, tow of 0x80000000, fix of 0xFF
    send_byte(SYNC1);
    send_byte(SYNC2);
    send_byte(8'h01);
    send_byte(ID_STA);
    foreach (sta_body[i]) send_byte(sta_body[i]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase(0, 0, 40);
    run_phase(65, 0, 40);
    run_phase(0, 65, 40);
    run_phase(22, 22, 40);
    s_tvalid <= 1'b0;

    // drain the outstanding fields, then watch for stray beats
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
